>>> design/rgcd_pkg.sv
// Shared types and constants for the running GCD unit.
// No dependencies; every other design file refers to this package by scoped names.
package rgcd_pkg;

   localparam int unsigned VALUE_WIDTH = 32;
   localparam int unsigned VALUE_W     = 32;
   localparam int unsigned GCD_RESULT_W = 32;
   localparam int unsigned SHIFT_W     = $clog2(VALUE_WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;   // take the accepted request into the operand registers
      logic step;   // one binary GCD iteration
      logic store;  // write the finished GCD back to the running value
      logic emit;   // move the running value to the response register and clear
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic skip;      // first element of a sequence, or running value already one
      logic done;      // one operand has reached zero
      logic last;      // the request in flight closes its sequence
      logic out_free;  // response register can take a new result this cycle
   } stat_type;

endpackage

>>> design/rgcd_req_if.sv
// Request channel: valid/ready handshake carrying one sequence element.
// Depends on rgcd_pkg for field widths.
interface rgcd_req_if;
   logic                             valid;
   logic                             ready;
   logic [rgcd_pkg::VALUE_W-1:0]     value;
   logic                             last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

>>> design/rgcd_rsp_if.sv
// Response channel: valid/ready handshake carrying one sequence GCD.
// Depends on rgcd_pkg for field widths.
interface rgcd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [rgcd_pkg::GCD_RESULT_W-1:0]  gcd_result;

   modport source (output valid, output gcd_result, input ready);
   modport sink   (input valid, input gcd_result, output ready);
endinterface

>>> design/rgcd_ctrl.sv
// Sequencing state machine of the running GCD unit.
// Depends on rgcd_pkg (state, command and status types).
module rgcd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rgcd_pkg::stat_type  stat,
   output rgcd_pkg::cmd_type   cmd
);

   rgcd_pkg::state_type state_ff, state_in;

   assign req_ready = (state_ff == rgcd_pkg::ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      unique case (state_ff)
         rgcd_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = stat.skip ? rgcd_pkg::ST_DONE : rgcd_pkg::ST_CALC;
            end
         end
         rgcd_pkg::ST_CALC: begin
            if (stat.done) begin
               cmd.store = 1'b1;
               state_in  = rgcd_pkg::ST_DONE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         rgcd_pkg::ST_DONE: begin
            // a closing request holds here until the response register is free
            if (!stat.last) begin
               state_in = rgcd_pkg::ST_IDLE;
            end else if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = rgcd_pkg::ST_IDLE;
            end
         end
         default: state_in = rgcd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rgcd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/rgcd_dp.sv
// Datapath of the running GCD unit: running value, binary GCD operands and
// the response register. Depends on rgcd_pkg (widths, command and status types).
module rgcd_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [rgcd_pkg::VALUE_W-1:0]           req_value,
   input  logic                                   req_last,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output logic [rgcd_pkg::GCD_RESULT_W-1:0]      rsp_gcd_result,
   input  rgcd_pkg::cmd_type                      cmd,
   output rgcd_pkg::stat_type                     stat
);

   localparam int unsigned W = rgcd_pkg::VALUE_WIDTH;

   logic [W-1:0]                      run_ff, run_in;
   logic                              first_ff, first_in;
   logic [W-1:0]                      a_ff, a_in;
   logic [W-1:0]                      b_ff, b_in;
   logic [rgcd_pkg::SHIFT_W-1:0]      k_ff, k_in;
   logic                              last_ff, last_in;
   logic                              valid_ff, valid_in;
   logic [rgcd_pkg::GCD_RESULT_W-1:0] out_ff, out_in;
   logic [W-1:0]                      v_in;

   assign v_in = req_value[W-1:0];

   assign stat.skip     = first_ff || (run_ff == W'(1));
   assign stat.done     = (a_ff == '0) || (b_ff == '0);
   assign stat.last     = last_ff;
   assign stat.out_free = !valid_ff || rsp_ready;

   assign rsp_valid      = valid_ff;
   assign rsp_gcd_result = out_ff;

   always_comb begin
      run_in   = run_ff;
      first_in = first_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      k_in     = k_ff;
      last_in  = last_ff;
      out_in   = out_ff;
      valid_in = valid_ff && !rsp_ready;

      if (cmd.load) begin
         a_in    = v_in;
         b_in    = run_ff;
         k_in    = '0;
         last_in = req_last;
         if (first_ff) begin
            run_in   = v_in;
            first_in = 1'b0;
         end
      end

      if (cmd.step) begin
         // drop common factors of two first, then strip odd-even, then subtract
         priority if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + rgcd_pkg::SHIFT_W'(1);
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff >= b_ff) begin
            a_in = a_ff - b_ff;
         end else begin
            b_in = b_ff - a_ff;
         end
      end

      // one operand is zero, so the OR is the other one
      if (cmd.store) begin
         run_in = (a_ff | b_ff) << k_ff;
      end

      if (cmd.emit) begin
         out_in   = rgcd_pkg::GCD_RESULT_W'(run_ff);
         valid_in = 1'b1;
         run_in   = '0;
         first_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= '0;
         first_ff <= 1'b1;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         run_ff   <= run_in;
         first_ff <= first_in;
         valid_ff <= valid_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      k_ff   <= k_in;
      out_ff <= out_in;
   end

endmodule

>>> design/running_gcd_of_sequence_unit.sv
// Running GCD unit top level: controller plus datapath behind two handshake channels.
// Depends on rgcd_pkg, rgcd_req_if, rgcd_rsp_if, rgcd_ctrl and rgcd_dp.
//
// Usage:
//   req_ch carries one unsigned element (value) per request, with last set on
//   the final element of a sequence. rsp_ch returns one gcd_result per
//   sequence, after its last request; other requests give no response.
//   The first element of a sequence loads the running value as it is; each
//   later one folds in with gcd(element, running), gcd(x, 0) = x.
// Timing:
//   One request is in work at a time. A request that opens a sequence, or
//   finds the running value already one, goes from load straight to the
//   final state; any other request runs the binary GCD iterations in the
//   single subtract-and-shift unit of the datapath, one step per cycle, then
//   writes the result back to the running value before the final state.
//   A response is visible the cycle after the last request finishes.
// Reset:
//   Synchronous, active high; clears the running value, marks the next
//   request as the start of a sequence and empties the response register.
// Stalls:
//   A waiting response does not block requests that do not close a sequence;
//   a closing request holds in its final state until the response is taken.
module running_gcd_of_sequence_unit (
   input  logic         clock,
   input  logic         reset,
   rgcd_req_if.sink     req_ch,
   rgcd_rsp_if.source   rsp_ch
);

   rgcd_pkg::cmd_type  cmd;
   rgcd_pkg::stat_type stat;

   // sequencing: when to accept, iterate, write back and emit
   rgcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // operands, running value and the response register
   rgcd_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_value      (req_ch.value),
      .req_last       (req_ch.last),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_gcd_result (rsp_ch.gcd_result),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule

>>> sim/running_gcd_of_sequence_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the running GCD unit: directed table, then random sequences.
// Depends on rgcd_pkg, rgcd_req_if, rgcd_rsp_if and the running_gcd_of_sequence_unit RTL.
module running_gcd_of_sequence_unit_tb;

   localparam int unsigned REQUEST_COUNT = 1500;  // stop stimulus after about this many requests
   localparam int unsigned CALM_TAIL     = 150;   // final requests run with no idling
   localparam int unsigned STALL_LIMIT   = 4000;  // cycles with no handshake before giving up
   localparam int unsigned DRAIN_CYCLES  = 200;   // settle time after the last response
   localparam int unsigned DIRECTED_ROWS = 23;

   typedef logic [rgcd_pkg::VALUE_W-1:0]      elem_type;
   typedef logic [rgcd_pkg::VALUE_WIDTH-1:0]  acc_type;
   typedef logic [rgcd_pkg::GCD_RESULT_W-1:0] gcd_type;

   // One directed request; typed rows carry a result that is plain at a glance
   typedef struct packed {
      elem_type value;
      logic     last;
      logic     typed;
      gcd_type  gcd;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rgcd_req_if req_ch ();
   rgcd_rsp_if rsp_ch ();

   running_gcd_of_sequence_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #2 clock = ~clock;

   // Predictor state: running GCD and the start-of-sequence flag
   acc_type     run_gcd;
   bit          seq_open;
   gcd_type     expected_gcds[$];

   int unsigned mismatches     = 0;
   int unsigned requests_sent  = 0;
   int unsigned sequences_sent = 0;
   int unsigned responses_seen = 0;
   int unsigned quiet_cycles   = 0;
   int unsigned gap_odds       = 4;   // one request in gap_odds is followed by an idle burst
   bit          calm           = 1'b0;
   gcd_type     oldest_gcd;

   // Directed table: extremes, zeros, early collapse to one and a worst-case Euclid pair
   stim_row_type directed [DIRECTED_ROWS] = '{
      '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},   // straight after reset, lone zero
      '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},   // lone maximum
      '{32'h0000_0001, 1'b1, 1'b1, 32'h0000_0001},   // lone one
      '{32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},   // all zeros gives zero
      '{32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
      '{32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},   // zeros leave the GCD alone
      '{32'h0000_000C, 1'b0, 1'b0, 32'h0000_0000},
      '{32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{32'h0000_0012, 1'b1, 1'b0, 32'h0000_0000},
      '{32'h0000_0007, 1'b0, 1'b0, 32'h0000_0000},   // coprime pair pins the value at one
      '{32'h0000_0005, 1'b0, 1'b0, 32'h0000_0000},
      '{32'hFFFF_FFFE, 1'b0, 1'b0, 32'h0000_0000},
      '{32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{32'h0000_03E8, 1'b1, 1'b1, 32'h0000_0001},
      '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000},
      '{32'hFFFF_FFFE, 1'b1, 1'b0, 32'h0000_0000},
      '{32'h8000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{32'h4000_0000, 1'b1, 1'b0, 32'h0000_0000},
      '{32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},   // zero then maximum
      '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
      '{32'd1836311903, 1'b0, 1'b0, 32'h0000_0000},  // consecutive Fibonacci numbers
      '{32'd2971215073, 1'b1, 1'b0, 32'h0000_0000}
   };

   // Euclidean remainder loop, gcd(a, 0) = a
   function automatic acc_type euclid_gcd(acc_type a, acc_type b);
      acc_type r;
      while (b != '0) begin
         r = a % b;
         a = b;
         b = r;
      end
      return a;
   endfunction

   // Fold one element into the running GCD; return 1 when it closes a sequence
   function automatic bit fold_element(elem_type value, logic last, output gcd_type gcd);
      acc_type v;
      v   = acc_type'(value);
      gcd = '0;
      if (seq_open) begin
         run_gcd  = v;
         seq_open = 1'b0;
      end else if (run_gcd != acc_type'(1)) begin
         run_gcd = euclid_gcd(v, run_gcd);
      end
      if (last) begin
         gcd      = gcd_type'(run_gcd);
         run_gcd  = '0;
         seq_open = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic report_mismatch(string what, gcd_type want, gcd_type got);
      $display("[%0t] mismatch: %s: expected %h, got %h", $realtime, what, want, got);
      mismatches++;
   endtask

   // Drive one request, hold it until taken, then predict and maybe idle
   task automatic send_request(elem_type value, logic last, logic typed, gcd_type typed_gcd);
      gcd_type gcd;
      req_ch.valid <= 1'b1;
      req_ch.value <= value;
      req_ch.last  <= last;
      do @(posedge clock); while (!req_ch.ready);
      requests_sent++;
      if (last) sequences_sent++;
      if (fold_element(value, last, gcd))
         expected_gcds.push_back(typed ? typed_gcd : gcd);
      calm = (requests_sent >= REQUEST_COUNT - CALM_TAIL);
      if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // Hold the sender off until every outstanding result has come back
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      while (expected_gcds.size() != 0) @(posedge clock);
   endtask

   // Pick one element of a random sequence according to its flavour
   function automatic elem_type pick_element(int unsigned flavour, elem_type factor);
      case (flavour)
         0, 1, 2, 3, 4: begin
            // multiples of a shared factor keep the GCD above one for long
            if ($urandom_range(0, 7) == 0) return '0;
            return factor * elem_type'($urandom_range(0, 32'hFFFF_FFFF / factor));
         end
         5, 6:    return elem_type'($urandom >> $urandom_range(0, 31));
         7: begin
            case ($urandom_range(0, 5))
               0:       return 32'h0000_0000;
               1:       return 32'h0000_0001;
               2:       return 32'hFFFF_FFFF;
               3:       return 32'hFFFF_FFFE;
               4:       return 32'h8000_0000;
               default: return elem_type'(1) << $urandom_range(0, 31);
            endcase
         end
         8:       return elem_type'($urandom_range(1, 15)) << $urandom_range(0, 27);
         default: return elem_type'($urandom);
      endcase
   endfunction

   // Send one random sequence, mostly short, now and then long
   task automatic play_sequence();
      int unsigned flavour;
      int unsigned length;
      elem_type    factor;
      flavour = $urandom_range(0, 9);
      length  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      factor  = elem_type'($urandom >> $urandom_range(4, 31));
      if (factor == '0) factor = elem_type'(1);
      for (int unsigned n = 0; n < length; n++)
         send_request(pick_element(flavour, factor), (n == length - 1), 1'b0, '0);
   endtask

   // Response side: random back-pressure bursts, always ready in the calm tail
   initial begin : response_sink
      int unsigned hold;
      hold = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (calm) begin
            rsp_ch.ready <= 1'b1;
         end else if (hold != 0) begin
            hold--;
         end else if (rsp_ch.ready && $urandom_range(0, 2) == 0) begin
            rsp_ch.ready <= 1'b0;
            hold = $urandom_range(1, 17) - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
         end
      end
   end

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         responses_seen++;
         if (expected_gcds.size() == 0) begin
            report_mismatch("response with nothing outstanding", '0, rsp_ch.gcd_result);
         end else begin
            oldest_gcd = expected_gcds.pop_front();
            if (rsp_ch.gcd_result !== oldest_gcd)
               report_mismatch("gcd_result", oldest_gcd, rsp_ch.gcd_result);
         end
      end
   end

   // Watchdog: end the run when no handshake happens for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("[%0t] watchdog: no handshake for %0d cycles, %0d results outstanding",
                  $realtime, STALL_LIMIT, expected_gcds.size());
         $display("FAIL running_gcd_of_sequence_unit");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      bit paused;
      paused = 1'b0;
      req_ch.valid <= 1'b0;
      req_ch.value <= '0;
      req_ch.last  <= 1'b0;
      run_gcd  = '0;
      seq_open = 1'b1;

      // hold reset asserted, then drop it
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int unsigned i = 0; i < DIRECTED_ROWS; i++)
         send_request(directed[i].value, directed[i].last, directed[i].typed, directed[i].gcd);

      // sender waits for a fully empty pipeline before the random part
      wait_for_results();

      while (requests_sent < REQUEST_COUNT) begin
         // vary the idling: none, light or heavy, per sequence
         case ($urandom_range(0, 3))
            0:       gap_odds = 0;
            1:       gap_odds = 2;
            default: gap_odds = 6;
         endcase
         play_sequence();
         if (!paused && requests_sent > REQUEST_COUNT / 2) begin
            wait_for_results();
            paused = 1'b1;
         end
      end
      req_ch.valid <= 1'b0;

      // drain, then let the block settle
      while (expected_gcds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d requests in %0d sequences with %0d responses checked.",
               requests_sent, sequences_sent, responses_seen);
      $display("Stimulus mixed shared-factor, random, extreme and power-of-two elements.");
      if (mismatches == 0) begin
         $display("PASS running_gcd_of_sequence_unit");
      end else begin
         $display("FAIL running_gcd_of_sequence_unit");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/rgcd_pkg.sv
design/rgcd_req_if.sv
design/rgcd_rsp_if.sv
design/rgcd_ctrl.sv
design/rgcd_dp.sv
design/running_gcd_of_sequence_unit.sv
sim/running_gcd_of_sequence_unit_tb.sv
